[hdl/chacha20_stream_xor_top_macros.svh]
// Assertion macros for the stream cipher block.
// Define NO_ASSERTIONS to compile them away.
`ifndef CHACHA20_STREAM_XOR_TOP_MACROS_SVH
`define CHACHA20_STREAM_XOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/chacha_pkg.sv]
`default_nettype none

package chacha_pkg;

    typedef logic [31:0] t_word;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    // Block constant words ("expand 32-byte k")
    localparam t_word SIGMA_0 = 32'h61707865;
    localparam t_word SIGMA_1 = 32'h3320646e;
    localparam t_word SIGMA_2 = 32'h79622d32;
    localparam t_word SIGMA_3 = 32'h6b206574;

    // Rotate amounts of the four quarter-round steps
    localparam int ROT_0 = 16;
    localparam int ROT_1 = 12;
    localparam int ROT_2 = 8;
    localparam int ROT_3 = 7;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY_0      = 3'd0;
    localparam logic [2:0] REG_KEY_1      = 3'd1;
    localparam logic [2:0] REG_KEY_2      = 3'd2;
    localparam logic [2:0] REG_KEY_3      = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [2:0] REG_INIT_CTR   = 3'd6;

    localparam logic [31:0] INIT_CTR_RESET = 32'd1;

    // Rotate left by the amount of the given quarter-round step
    function automatic t_word rotl_step(input t_word v, input logic [1:0] step);
        t_word r;
        case (step)
            2'd0:    r = (v << ROT_0) | (v >> (32 - ROT_0));
            2'd1:    r = (v << ROT_1) | (v >> (32 - ROT_1));
            2'd2:    r = (v << ROT_2) | (v >> (32 - ROT_2));
            2'd3:    r = (v << ROT_3) | (v >> (32 - ROT_3));
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/chacha20_stream_xor_top.sv]
// Channel   | Dir | Payload                                  | Handshake
// ----------+-----+------------------------------------------+-----------------------
// s_axis    | in  | tdata[7:0] data_byte, tlast last_byte    | tvalid / tready
// m_axis    | out | tdata[7:0] out_byte,  tlast last_out     | tvalid / tready
// APB cfg   | in  | paddr[5:3] register, pwdata[63:0]        | psel/penable/pwrite
//
// A byte at block position 0 first runs the block: four quarter-round lanes do one
// add-xor-rotate step per cycle, then the input words are added back, one row at a
// time. Any other byte is accepted, then XORed into the output register.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the block in its emit state; input is refused until then.
`default_nettype none

`include "chacha20_stream_xor_top_macros.svh"

module chacha20_stream_xor_top #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,    // last_byte
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,    // [7:0] out_byte
    output logic             o_m_axis_tlast,    // last_out
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    import chacha_pkg::*;

    localparam int STEPS = DOUBLE_ROUNDS * 8;
    localparam int SW    = $clog2(STEPS);

    // Control state
    t_state      r_state, n_state;
    logic [SW-1:0] r_step;
    logic [1:0]  r_row;
    logic [5:0]  r_pos;
    logic        r_msg_start;
    logic [31:0] r_counter;
    logic        r_out_valid;

    // Configuration registers
    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce_low;
    logic [31:0] r_nonce_high, r_init_ctr;

    // Payload
    logic [3:0][3:0][31:0] r_st;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    // Combinational
    logic        w_accept;
    logic        w_emit;
    logic        w_cfg_wr;
    logic        w_last_step;
    logic [31:0] w_blk_ctr;
    logic [3:0][3:0][31:0] w_init;
    logic [3:0][3:0][31:0] w_arx;
    logic [3:0][3:0][31:0] w_shuf;
    logic [31:0] w_word;
    logic [7:0]  w_ks_byte;

    // Handshakes
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_last_step = (r_step == SW'(STEPS - 1));

    // Counter of the block being built: reload at a message start
    assign w_blk_ctr = ((r_state == S_IDLE) && r_msg_start) ? r_init_ctr : r_counter;

    // Input words of the block, row by row
    always_comb begin
        w_init[0][0] = SIGMA_0;
        w_init[0][1] = SIGMA_1;
        w_init[0][2] = SIGMA_2;
        w_init[0][3] = SIGMA_3;
        w_init[1][0] = r_key0[31:0];
        w_init[1][1] = r_key0[63:32];
        w_init[1][2] = r_key1[31:0];
        w_init[1][3] = r_key1[63:32];
        w_init[2][0] = r_key2[31:0];
        w_init[2][1] = r_key2[63:32];
        w_init[2][2] = r_key3[31:0];
        w_init[2][3] = r_key3[63:32];
        w_init[3][0] = w_blk_ctr;
        w_init[3][1] = r_nonce_low[31:0];
        w_init[3][2] = r_nonce_low[63:32];
        w_init[3][3] = r_nonce_high;
    end

    // Shared quarter-round unit: one add-xor-rotate step on four lanes
    always_comb begin
        w_arx = r_st;
        for (int l = 0; l < 4; l++) begin
            if (!r_step[0]) begin
                w_arx[0][l] = r_st[0][l] + r_st[1][l];
                w_arx[3][l] = rotl_step(r_st[3][l] ^ w_arx[0][l], r_step[1:0]);
            end else begin
                w_arx[2][l] = r_st[2][l] + r_st[3][l];
                w_arx[1][l] = rotl_step(r_st[1][l] ^ w_arx[2][l], r_step[1:0]);
            end
        end
    end

    // After a column round turn diagonals into columns; after a diagonal round undo it
    always_comb begin
        w_shuf = w_arx;
        if (r_step[1:0] == 2'd3) begin
            for (int rr = 1; rr < 4; rr++) begin
                for (int l = 0; l < 4; l++) begin
                    if (r_step[2]) begin
                        w_shuf[rr][l] = w_arx[rr][2'(l - rr)];
                    end else begin
                        w_shuf[rr][l] = w_arx[rr][2'(l + rr)];
                    end
                end
            end
        end
    end

    // Keystream byte at the current position
    assign w_word    = r_st[r_pos[5:4]][r_pos[3:2]];
    assign w_ks_byte = w_word[{r_pos[1:0], 3'b000} +: 8];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (r_pos == 6'd0) ? S_ROUND : S_EMIT;
                end
            end
            S_ROUND: begin
                if (w_last_step) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_row == 2'd3) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_m_axis_tvalid = r_out_valid;
        o_m_axis_tdata  = r_out_byte;
        o_m_axis_tlast  = r_out_last;
        pready          = 1'b1;
    end

    // Register read-back
    always_comb begin
        case (paddr[5:3])
            REG_KEY_0:      prdata = r_key0;
            REG_KEY_1:      prdata = r_key1;
            REG_KEY_2:      prdata = r_key2;
            REG_KEY_3:      prdata = r_key3;
            REG_NONCE_LOW:  prdata = r_nonce_low;
            REG_NONCE_HIGH: prdata = {32'd0, r_nonce_high};
            REG_INIT_CTR:   prdata = {32'd0, r_init_ctr};
            default:        prdata = 64'd0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_row        <= 2'd0;
            r_pos        <= 6'd0;
            r_msg_start  <= 1'b1;
            r_counter    <= INIT_CTR_RESET;
            r_out_valid  <= 1'b0;
            r_key0       <= 64'd0;
            r_key1       <= 64'd0;
            r_key2       <= 64'd0;
            r_key3       <= 64'd0;
            r_nonce_low  <= 64'd0;
            r_nonce_high <= 32'd0;
            r_init_ctr   <= INIT_CTR_RESET;
        end else begin
            r_state <= n_state;

            // Accept a request; load the block counter when a block starts
            if (w_accept) begin
                r_msg_start <= 1'b0;
                r_step      <= '0;
                r_row       <= 2'd0;
                if (r_pos == 6'd0) begin
                    r_counter <= w_blk_ctr;
                end
            end

            // Advance the round sequencer
            if (r_state == S_ROUND) begin
                r_step <= r_step + 1'b1;
            end

            // Advance the add-back row; bump the counter after the block
            if (r_state == S_ADD) begin
                r_row <= r_row + 2'd1;
                if (r_row == 2'd3) begin
                    r_counter <= r_counter + 32'd1;
                end
            end

            // Emit: advance the position, or restart after the last byte
            if (w_emit) begin
                r_pos       <= r_in_last ? 6'd0 : r_pos + 6'd1;
                r_msg_start <= r_in_last;
            end

            // Output register
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes
            if (w_cfg_wr) begin
                case (paddr[5:3])
                    REG_KEY_0:      r_key0       <= pwdata;
                    REG_KEY_1:      r_key1       <= pwdata;
                    REG_KEY_2:      r_key2       <= pwdata;
                    REG_KEY_3:      r_key3       <= pwdata;
                    REG_NONCE_LOW:  r_nonce_low  <= pwdata;
                    REG_NONCE_HIGH: r_nonce_high <= pwdata[31:0];
                    REG_INIT_CTR:   r_init_ctr   <= pwdata[31:0];
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Hold the request payload
        if (w_accept) begin
            r_in_data <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end

        // Load the block words, run the rounds, add the input words back
        if (w_accept && (r_pos == 6'd0)) begin
            r_st <= w_init;
        end else if (r_state == S_ROUND) begin
            r_st <= w_shuf;
        end else if (r_state == S_ADD) begin
            for (int l = 0; l < 4; l++) begin
                r_st[r_row][l] <= r_st[r_row][l] + w_init[r_row][l];
            end
        end

        if (w_emit) begin
            r_out_byte <= r_in_data ^ w_ks_byte;
            r_out_last <= r_in_last;
        end
    end

    // Checks
    `CHK_IMPLY(a_round_at_pos0, i_clk, i_rst_n, r_state == S_ROUND, r_pos == 6'd0)
    `CHK_IMPLY(a_add_after_rounds, i_clk, i_rst_n, (r_state == S_ADD) && (r_row == 2'd0), $past(r_state) == S_ROUND)
    `CHK_NEXT(a_emit_loads_out, i_clk, i_rst_n, w_emit, o_m_axis_tvalid && (r_state == S_IDLE))

endmodule

`default_nettype wire
